// ===== src/arlf_pkg.sv =====
// Shared types, codes, widths and character constants of the AT response line framer.
package arlf_pkg;

    localparam int BUFFER_DEPTH = 1024;
    localparam int MODE_W       = 2;
    localparam int BYTE_W       = 8;
    localparam int RIDX_W       = 10;
    localparam int EV_W         = 3;
    localparam int LEN_W        = 11;
    localparam int CFG_W        = 16;

    localparam logic [CFG_W-1:0] TIMEOUT_RESET = 16'd5000;

    localparam logic [BYTE_W-1:0] CH_CR     = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_LF     = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_COMMA  = 8'h2C;
    localparam logic [BYTE_W-1:0] CH_PLUS   = 8'h2B;
    localparam logic [BYTE_W-1:0] CH_PROMPT = 8'h3E;
    localparam logic [BYTE_W-1:0] CH_ZERO   = 8'h30;
    localparam logic [BYTE_W-1:0] CH_NINE   = 8'h39;

    typedef enum logic [MODE_W-1:0] {
        MODE_BYTE = 2'd0,
        MODE_TICK = 2'd1,
        MODE_READ = 2'd2,
        MODE_NOP  = 2'd3
    } t_mode;

    typedef enum logic [EV_W-1:0] {
        EV_NONE      = 3'd0,
        EV_LINE      = 3'd1,
        EV_LINE_MORE = 3'd2,
        EV_FRAME     = 3'd3,
        EV_PROMPT    = 3'd4,
        EV_DISCARD   = 3'd5
    } t_event;

endpackage

// ===== src/arlf_ifs.sv =====
// Valid/ready channel interfaces for framer input items and result items.
interface arlf_in_if;
    logic                             valid;
    logic                             ready;
    logic [arlf_pkg::MODE_W-1:0]      mode;
    logic [arlf_pkg::BYTE_W-1:0]      rx_byte;
    logic [arlf_pkg::RIDX_W-1:0]      read_index;

    modport source (output valid, output mode, output rx_byte, output read_index, input ready);
    modport sink   (input valid, input mode, input rx_byte, input read_index, output ready);
endinterface

interface arlf_out_if;
    logic                             valid;
    logic                             ready;
    logic [arlf_pkg::EV_W-1:0]        event_res;
    logic [arlf_pkg::LEN_W-1:0]       message_length;
    logic [arlf_pkg::BYTE_W-1:0]      read_data;

    modport source (output valid, output event_res, output message_length, output read_data,
                    input ready);
    modport sink   (input valid, input event_res, input message_length, input read_data,
                    output ready);
endinterface

// ===== src/at_response_line_framer.sv =====
// AT response line framer: parser, idle timer, message buffer and header length walker.
// Flow: an accepted item's result goes through S_PUSH to the output register, where it can
//   wait on a held output. One item at a time; the LF that closes a '+' header runs longer,
//   through S_HDR_CR, S_BACK and S_FWD, walking back to the last comma and over the digits
//   after it through the single read port of the message buffer, one entry per cycle.
// Reset (synchronous, active low): parser waits for a head CR, write index 0, timer off,
//   timeout register 5000. The message buffer is not cleared; it is undefined until written.
module at_response_line_framer #(
    parameter int BUFFER_DEPTH = arlf_pkg::BUFFER_DEPTH  // power of two
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    arlf_in_if.sink                       i_in,
    arlf_out_if.source                    o_out,
    input  logic                          i_cfg_we,
    input  logic [arlf_pkg::CFG_W-1:0]    i_cfg_wdata
);

    localparam int AW  = $clog2(BUFFER_DEPTH);  // buffer address bits
    localparam int WIW = AW + 1;                // write index, holds BUFFER_DEPTH itself
    localparam logic [WIW-1:0] DEPTH_WI = WIW'(BUFFER_DEPTH);

    // Parser states, one-hot
    typedef enum logic [6:0] {
        PS_HEAD_CR   = 7'b0000001,
        PS_HEAD_LF   = 7'b0000010,
        PS_MSG       = 7'b0000100,
        PS_CONT      = 7'b0001000,
        PS_TAIL_LF   = 7'b0010000,
        PS_RECV_HEAD = 7'b0100000,
        PS_FRAME     = 7'b1000000
    } t_parse;

    // Item sequencer states, one-hot
    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,  // take an item
        S_HDR_CR = 5'b00010,  // check the byte before the header LF
        S_BACK   = 5'b00100,  // walk back to the last comma
        S_FWD    = 5'b01000,  // walk forward over the digits
        S_PUSH   = 5'b10000   // move the result to the output register
    } t_seq;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    t_seq                           r_seq,      n_seq;
    t_parse                         r_parse,    n_parse;
    logic [WIW-1:0]                 r_wi,       n_wi;
    logic [15:0]                    r_fr,       n_fr;
    logic [15:0]                    r_cnt,      n_cnt;
    logic                           r_armed,    n_armed;
    logic [arlf_pkg::CFG_W-1:0]     r_timeout;
    logic [AW-1:0]                  r_scan,     n_scan;
    logic [15:0]                    r_hlen,     n_hlen;
    arlf_pkg::t_event               r_pend_ev,  n_pend_ev;
    logic [arlf_pkg::LEN_W-1:0]     r_pend_len, n_pend_len;
    logic                           r_pend_rd,  n_pend_rd;
    logic                           r_out_valid;
    arlf_pkg::t_event               r_out_ev;
    logic [arlf_pkg::LEN_W-1:0]     r_out_len;
    logic [arlf_pkg::BYTE_W-1:0]    r_out_data;

    // Message buffer: one write port, one registered read port
    logic [arlf_pkg::BYTE_W-1:0]    r_msg_buf [BUFFER_DEPTH];
    logic [arlf_pkg::BYTE_W-1:0]    r_rd_data;
    logic                           mem_we;
    logic [AW-1:0]                  mem_waddr;
    logic [arlf_pkg::BYTE_W-1:0]    mem_wdata;
    logic                           mem_re;
    logic [AW-1:0]                  mem_raddr;

    // ------------------------------------------------------------------
    // Handshake
    // ------------------------------------------------------------------
    logic in_acc;
    logic out_free;
    logic push;

    assign i_in.ready = (r_seq == S_IDLE);
    assign in_acc     = i_in.valid && (r_seq == S_IDLE);
    assign out_free   = !r_out_valid || o_out.ready;
    assign push       = (r_seq == S_PUSH) && out_free;

    assign o_out.valid          = r_out_valid;
    assign o_out.event_res      = r_out_ev;
    assign o_out.message_length = r_out_len;
    assign o_out.read_data      = r_out_data;

    // ------------------------------------------------------------------
    // Byte preprocessing: an expired timer drops the partial message silently,
    // and an index at the buffer end wraps before the byte is stored.
    // ------------------------------------------------------------------
    logic                        byte_drop;
    logic [WIW-1:0]              wi0;
    logic [WIW-1:0]              wi1;
    logic [WIW-1:0]              wi_inc;
    t_parse                      st0;
    logic [15:0]                 fr_dec;
    logic [15:0]                 cnt_dec;
    logic [arlf_pkg::LEN_W-1:0]  line_len;
    logic [arlf_pkg::BYTE_W-1:0] rx;

    assign rx        = i_in.rx_byte;
    assign byte_drop = r_armed && (r_cnt == '0);
    assign wi0       = byte_drop ? '0 : r_wi;
    assign wi1       = (wi0 == DEPTH_WI) ? '0 : wi0;
    assign wi_inc    = wi1 + WIW'(1);
    assign st0       = byte_drop ? PS_HEAD_CR : r_parse;
    assign fr_dec    = (r_fr != '0) ? r_fr - 16'd1 : r_fr;
    assign cnt_dec   = (r_cnt != '0) ? r_cnt - 16'd1 : r_cnt;
    assign line_len  = arlf_pkg::LEN_W'(wi_inc);

    // ------------------------------------------------------------------
    // Header digit accumulation: len*10 + digit, saturating at 65535
    // ------------------------------------------------------------------
    logic [arlf_pkg::BYTE_W-1:0] digit_val;
    logic                        is_digit;
    logic [19:0]                 hlen_acc;
    logic [15:0]                 hlen_sat;

    assign digit_val = r_rd_data - arlf_pkg::CH_ZERO;
    assign is_digit  = (r_rd_data >= arlf_pkg::CH_ZERO) && (r_rd_data <= arlf_pkg::CH_NINE);
    assign hlen_acc  = ({4'b0, r_hlen} << 3) + ({4'b0, r_hlen} << 1) + 20'(digit_val[3:0]);
    assign hlen_sat  = (hlen_acc > 20'd65535) ? 16'hFFFF : hlen_acc[15:0];

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    logic                        do_restart;
    logic                        finish;
    arlf_pkg::t_event            ev;
    logic [arlf_pkg::LEN_W-1:0]  len;
    logic                        take_rd;

    always_comb begin
        n_seq      = r_seq;
        n_parse    = r_parse;
        n_wi       = r_wi;
        n_fr       = r_fr;
        n_cnt      = r_cnt;
        n_armed    = r_armed;
        n_scan     = r_scan;
        n_hlen     = r_hlen;
        n_pend_ev  = r_pend_ev;
        n_pend_len = r_pend_len;
        n_pend_rd  = r_pend_rd;
        mem_we     = 1'b0;
        mem_waddr  = wi1[AW-1:0];
        mem_wdata  = rx;
        mem_re     = 1'b0;
        mem_raddr  = AW'(i_in.read_index);
        do_restart = 1'b0;
        finish     = 1'b0;
        ev         = arlf_pkg::EV_NONE;
        len        = '0;
        take_rd    = 1'b0;

        unique case (r_seq)
            S_IDLE: begin
                if (in_acc) begin
                    finish = 1'b1;
                    unique case (arlf_pkg::t_mode'(i_in.mode))
                        arlf_pkg::MODE_BYTE: begin
                            // store the byte, reload the idle timer
                            mem_we  = 1'b1;
                            n_cnt   = r_timeout;
                            n_armed = 1'b1;
                            n_wi    = wi1;
                            n_parse = st0;
                            unique case (st0)
                                PS_HEAD_CR: begin
                                    if (rx == arlf_pkg::CH_CR) begin
                                        n_parse = PS_HEAD_LF;
                                    end else if (rx == arlf_pkg::CH_PLUS) begin
                                        n_wi    = wi_inc;
                                        n_parse = PS_RECV_HEAD;
                                    end
                                end
                                PS_HEAD_LF: begin
                                    if (rx == arlf_pkg::CH_LF) begin
                                        n_parse = PS_MSG;
                                    end else if (rx != arlf_pkg::CH_CR) begin
                                        do_restart = 1'b1;
                                        ev         = arlf_pkg::EV_DISCARD;
                                    end
                                end
                                PS_MSG: begin
                                    if (rx == arlf_pkg::CH_PROMPT) begin
                                        do_restart = 1'b1;
                                        ev         = arlf_pkg::EV_PROMPT;
                                    end else if (rx == arlf_pkg::CH_CR) begin
                                        n_parse = PS_TAIL_LF;
                                    end else begin
                                        n_wi    = wi_inc;
                                        n_parse = PS_CONT;
                                    end
                                end
                                PS_CONT: begin
                                    if (rx == arlf_pkg::CH_CR) begin
                                        n_parse = PS_TAIL_LF;
                                    end else begin
                                        n_wi = wi_inc;
                                    end
                                end
                                PS_TAIL_LF: begin
                                    if (rx == arlf_pkg::CH_CR || rx == arlf_pkg::CH_LF) begin
                                        // terminate the line in place of its CR
                                        mem_wdata = '0;
                                        len       = line_len;
                                        if (rx == arlf_pkg::CH_CR) begin
                                            ev      = arlf_pkg::EV_LINE_MORE;
                                            n_wi    = '0;
                                            n_parse = PS_HEAD_LF;
                                        end else begin
                                            ev         = arlf_pkg::EV_LINE;
                                            do_restart = 1'b1;
                                        end
                                    end else begin
                                        do_restart = 1'b1;
                                        ev         = arlf_pkg::EV_DISCARD;
                                    end
                                end
                                PS_RECV_HEAD: begin
                                    if (rx == arlf_pkg::CH_LF) begin
                                        if (wi1 == '0) begin
                                            do_restart = 1'b1;
                                            ev         = arlf_pkg::EV_DISCARD;
                                        end else begin
                                            // start the header walk at the byte before LF
                                            finish    = 1'b0;
                                            mem_re    = 1'b1;
                                            mem_raddr = wi1[AW-1:0] - AW'(1);
                                            n_scan    = wi1[AW-1:0] - AW'(1);
                                            n_seq     = S_HDR_CR;
                                        end
                                    end else begin
                                        n_wi = wi_inc;
                                    end
                                end
                                PS_FRAME: begin
                                    n_fr = fr_dec;
                                    n_wi = wi_inc;
                                    if (fr_dec == '0) begin
                                        ev         = arlf_pkg::EV_FRAME;
                                        len        = line_len;
                                        do_restart = 1'b1;
                                    end
                                end
                                default: begin
                                    do_restart = 1'b1;
                                end
                            endcase
                        end
                        arlf_pkg::MODE_TICK: begin
                            if (r_armed) begin
                                n_cnt = cnt_dec;
                                if (cnt_dec == '0) begin
                                    if (r_parse != PS_HEAD_CR) begin
                                        ev = arlf_pkg::EV_DISCARD;
                                    end
                                    do_restart = 1'b1;
                                end
                            end
                        end
                        arlf_pkg::MODE_READ: begin
                            mem_re  = 1'b1;
                            take_rd = 1'b1;
                        end
                        arlf_pkg::MODE_NOP: begin
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_HDR_CR: begin
                if (r_rd_data != arlf_pkg::CH_CR) begin
                    do_restart = 1'b1;
                    ev         = arlf_pkg::EV_DISCARD;
                    finish     = 1'b1;
                end else begin
                    // zero the CR: it ends the digit walk
                    mem_we    = 1'b1;
                    mem_waddr = r_scan;
                    mem_wdata = '0;
                    if (r_scan == '0) begin
                        do_restart = 1'b1;
                        ev         = arlf_pkg::EV_DISCARD;
                        finish     = 1'b1;
                    end else begin
                        mem_re    = 1'b1;
                        mem_raddr = r_scan - AW'(1);
                        n_scan    = r_scan - AW'(1);
                        n_seq     = S_BACK;
                    end
                end
            end
            S_BACK: begin
                if (r_rd_data == arlf_pkg::CH_COMMA) begin
                    mem_re    = 1'b1;
                    mem_raddr = r_scan + AW'(1);
                    n_scan    = r_scan + AW'(1);
                    n_hlen    = '0;
                    n_seq     = S_FWD;
                end else if (r_scan == '0) begin
                    do_restart = 1'b1;
                    ev         = arlf_pkg::EV_DISCARD;
                    finish     = 1'b1;
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = r_scan - AW'(1);
                    n_scan    = r_scan - AW'(1);
                end
            end
            S_FWD: begin
                if (r_rd_data == '0) begin
                    finish = 1'b1;
                    if (r_hlen != '0) begin
                        n_fr    = r_hlen;
                        n_parse = PS_FRAME;
                    end else begin
                        do_restart = 1'b1;
                        ev         = arlf_pkg::EV_DISCARD;
                    end
                end else if (is_digit) begin
                    n_hlen    = hlen_sat;
                    mem_re    = 1'b1;
                    mem_raddr = r_scan + AW'(1);
                    n_scan    = r_scan + AW'(1);
                end else begin
                    do_restart = 1'b1;
                    ev         = arlf_pkg::EV_DISCARD;
                    finish     = 1'b1;
                end
            end
            S_PUSH: begin
                if (out_free) begin
                    n_seq = S_IDLE;
                end
            end
            default: begin
                n_seq = S_IDLE;
            end
        endcase

        // parser restart: back to the head CR, index 0, timer off
        if (do_restart) begin
            n_wi    = '0;
            n_armed = 1'b0;
            n_parse = PS_HEAD_CR;
        end

        if (finish) begin
            n_seq      = S_PUSH;
            n_pend_ev  = ev;
            n_pend_len = len;
            n_pend_rd  = take_rd;
        end
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq       <= S_IDLE;
            r_parse     <= PS_HEAD_CR;
            r_wi        <= '0;
            r_fr        <= '0;
            r_cnt       <= '0;
            r_armed     <= 1'b0;
            r_timeout   <= arlf_pkg::TIMEOUT_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_seq   <= n_seq;
            r_parse <= n_parse;
            r_wi    <= n_wi;
            r_fr    <= n_fr;
            r_cnt   <= n_cnt;
            r_armed <= n_armed;
            if (i_cfg_we) begin
                r_timeout <= i_cfg_wdata;
            end
            if (push) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        r_scan     <= n_scan;
        r_hlen     <= n_hlen;
        r_pend_ev  <= n_pend_ev;
        r_pend_len <= n_pend_len;
        r_pend_rd  <= n_pend_rd;
        if (push) begin
            r_out_ev   <= r_pend_ev;
            r_out_len  <= r_pend_len;
            r_out_data <= r_pend_rd ? r_rd_data : '0;
        end
    end

    // ------------------------------------------------------------------
    // Message buffer. Walk reads and the CR clear never hit the same entry
    // in one cycle, so no forwarding is needed.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_msg_buf[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd_data <= r_msg_buf[mem_raddr];
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_wi_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wi <= DEPTH_WI)
        else $error("write index beyond buffer depth");

    a_walk_below_lf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_seq == S_BACK || r_seq == S_FWD) |-> ({1'b0, r_scan} < r_wi))
        else $error("header walk left the header");

    a_walk_in_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_seq == S_HDR_CR || r_seq == S_BACK || r_seq == S_FWD) |-> r_parse == PS_RECV_HEAD)
        else $error("header walk outside header reception");

    a_item_not_lost: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_seq != S_IDLE)
        else $error("accepted item produced no work");

    a_out_from_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_seq == S_PUSH))
        else $error("result loaded without a pending item");

endmodule

// ===== tb/sv/arlf_result_check.sv =====
`timescale 1ns / 100ps
// Result checker for the AT response line framer: predicts every result and compares it.
module arlf_result_check
    import arlf_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    arlf_in_if                i_in,
    arlf_out_if               i_out,
    input  logic              i_cfg_we,
    input  logic [CFG_W-1:0]  i_cfg_wdata,
    input  logic              i_wrap_up,
    output int                o_mismatches,
    output int                o_filled
);

    typedef enum logic [2:0] {
        PS_HEAD_CR,
        PS_HEAD_LF,
        PS_MSG_OR_PROMPT,
        PS_CONT_MSG,
        PS_TAIL_LF,
        PS_RECV_HEAD,
        PS_FRAME
    } t_parse;

    typedef struct packed {
        t_event             ev;
        logic [LEN_W-1:0]   len;
        logic [BYTE_W-1:0]  data;
    } t_result;

    t_result            expected_q[$];
    logic [BYTE_W-1:0]  buf_mem [BUFFER_DEPTH];
    t_parse             pstate;
    int unsigned        wr_pos;
    int unsigned        frame_left;
    int unsigned        idle_left;
    bit                 idle_on;
    logic [CFG_W-1:0]   timeout_reg;
    int                 fill_mark;
    int                 mismatch_cnt;
    bit                 wrapped;

    initial begin
        mismatch_cnt = 0;
        fill_mark    = 0;
        wrapped      = 1'b0;
    end

    task automatic log_mismatch(input string what, input logic [31:0] got_v,
                                input logic [31:0] want_v);
        $display("%0t ns mismatch %s: got %0d expected %0d", $time, what, got_v, want_v);
        mismatch_cnt++;
    endtask

    function automatic void restart_parser();
        wr_pos  = 0;
        idle_on = 1'b0;
        pstate  = PS_HEAD_CR;
    endfunction

    // Walk back from the header's LF to its last comma, then read the digits forward.
    function automatic int unsigned header_len(input int unsigned pos);
        int unsigned cr_pos;
        int unsigned j;
        int unsigned acc;
        acc = 0;
        if (pos == 0 || pos > BUFFER_DEPTH) return 0;
        cr_pos = pos - 1;
        if (buf_mem[cr_pos] != CH_CR) return 0;
        buf_mem[cr_pos] = '0;
        if (cr_pos == 0) return 0;
        j = cr_pos - 1;
        while (j > 0 && buf_mem[j] != CH_COMMA) j--;
        if (buf_mem[j] != CH_COMMA) return 0;
        for (j = j + 1; j < BUFFER_DEPTH && buf_mem[j] != 0; j++) begin
            if (buf_mem[j] < CH_ZERO || buf_mem[j] > CH_NINE) return 0;
            acc = acc * 10 + (buf_mem[j] - CH_ZERO);
            if (acc > 65535) acc = 65535;
        end
        return acc;
    endfunction

    function automatic void take_byte(input logic [BYTE_W-1:0] b, inout t_result r);
        if (idle_on && idle_left == 0) begin
            wr_pos = 0;
            pstate = PS_HEAD_CR;
        end
        if (wr_pos >= BUFFER_DEPTH) wr_pos = 0;
        buf_mem[wr_pos] = b;
        if (wr_pos + 1 > fill_mark) fill_mark = wr_pos + 1;
        idle_left = timeout_reg;
        idle_on   = 1'b1;
        case (pstate)
            PS_HEAD_CR: begin
                if (b == CH_CR) begin
                    pstate = PS_HEAD_LF;
                end else if (b == CH_PLUS) begin
                    wr_pos++;
                    pstate = PS_RECV_HEAD;
                end
            end
            PS_HEAD_LF: begin
                if (b == CH_LF) begin
                    pstate = PS_MSG_OR_PROMPT;
                end else if (b != CH_CR) begin
                    restart_parser();
                    r.ev = EV_DISCARD;
                end
            end
            PS_MSG_OR_PROMPT: begin
                if (b == CH_PROMPT) begin
                    restart_parser();
                    r.ev = EV_PROMPT;
                end else if (b == CH_CR) begin
                    pstate = PS_TAIL_LF;
                end else begin
                    wr_pos++;
                    pstate = PS_CONT_MSG;
                end
            end
            PS_CONT_MSG: begin
                if (b == CH_CR) pstate = PS_TAIL_LF;
                else wr_pos++;
            end
            PS_TAIL_LF: begin
                if (b == CH_CR || b == CH_LF) begin
                    buf_mem[wr_pos] = '0;
                    r.len = LEN_W'(wr_pos + 1);
                    if (b == CH_CR) begin
                        r.ev   = EV_LINE_MORE;
                        wr_pos = 0;
                        pstate = PS_HEAD_LF;
                    end else begin
                        r.ev = EV_LINE;
                        restart_parser();
                    end
                end else begin
                    restart_parser();
                    r.ev = EV_DISCARD;
                end
            end
            PS_RECV_HEAD: begin
                if (b == CH_LF) begin
                    frame_left = header_len(wr_pos);
                    if (frame_left > 0) begin
                        pstate = PS_FRAME;
                    end else begin
                        restart_parser();
                        r.ev = EV_DISCARD;
                    end
                end else begin
                    wr_pos++;
                end
            end
            PS_FRAME: begin
                if (frame_left > 0) frame_left--;
                wr_pos++;
                if (frame_left == 0) begin
                    r.ev  = EV_FRAME;
                    r.len = LEN_W'(wr_pos);
                    restart_parser();
                end
            end
            default: restart_parser();
        endcase
    endfunction

    function automatic t_result framer_result(input logic [MODE_W-1:0] mode,
                                              input logic [BYTE_W-1:0] b,
                                              input logic [RIDX_W-1:0] ri);
        t_result r;
        r = '{ev: EV_NONE, len: '0, data: '0};
        case (t_mode'(mode))
            MODE_BYTE: take_byte(b, r);
            MODE_TICK: begin
                if (idle_on) begin
                    if (idle_left > 0) idle_left--;
                    if (idle_left == 0) begin
                        if (pstate != PS_HEAD_CR) r.ev = EV_DISCARD;
                        restart_parser();
                    end
                end
            end
            MODE_READ: r.data = buf_mem[ri];
            default: ;
        endcase
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        t_result want;
        if (!i_rst_n) begin
            restart_parser();
            frame_left  = 0;
            idle_left   = 0;
            timeout_reg = TIMEOUT_RESET;
            expected_q.delete();
        end else begin
            // Retire the result first: it can never belong to an item taken at this edge.
            if (i_out.valid && i_out.ready) begin
                if (expected_q.size() == 0) begin
                    log_mismatch("result with nothing pending, event_res", i_out.event_res, 0);
                end else begin
                    want = expected_q.pop_front();
                    if (i_out.event_res !== want.ev)
                        log_mismatch("event_res", i_out.event_res, want.ev);
                    if (i_out.message_length !== want.len)
                        log_mismatch("message_length", i_out.message_length, want.len);
                    if (i_out.read_data !== want.data)
                        log_mismatch("read_data", i_out.read_data, want.data);
                end
            end
            if (i_in.valid && i_in.ready)
                expected_q.push_back(framer_result(i_in.mode, i_in.rx_byte, i_in.read_index));
            if (i_cfg_we) timeout_reg = i_cfg_wdata;
            if (i_wrap_up && !wrapped) begin
                wrapped = 1'b1;
                if (expected_q.size() != 0)
                    log_mismatch("results never delivered", expected_q.size(), 0);
            end
        end
        o_mismatches <= mismatch_cnt;
        o_filled     <= fill_mark;
    end

endmodule

// ===== tb/sv/at_response_line_framer_tb.sv =====
`timescale 1ns / 100ps
// Testbench top for the AT response line framer: stimulus, handshake pacing and verdict.
module at_response_line_framer_tb;
    import arlf_pkg::*;

    // Results pass through the output register; a header LF first walks the header.
    localparam int SETTLE_CYCLES = 20;
    localparam int PHASE_ITEMS   = 200;
    localparam int OVERRUN_BYTES = 1030;

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    logic [CFG_W-1:0]  cfg_wdata;
    logic              wrap_up;
    int                mismatches;
    int                filled;
    int                sent;
    int                got;
    int                cur_timeout;
    bit                calm;

    arlf_in_if  in_ch ();
    arlf_out_if out_ch ();

    at_response_line_framer DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in        (in_ch.sink),
        .o_out       (out_ch.source),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    arlf_result_check u_result_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .i_wrap_up    (wrap_up),
        .o_mismatches (mismatches),
        .o_filled     (filled)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hold the run to a hard ceiling, ending it with an error verdict.
    initial begin
        #10_000_000;
        $display("at_response_line_framer_tb: errors");
        $finish;
    end

    // Stall the result side about 28 times in a hundred, never while calm.
    initial begin
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            out_ch.ready <= calm || ($urandom_range(99) >= 28);
        end
    end

    // Count delivered results so the stimulus knows when the block has drained.
    initial got = 0;
    always @(posedge clk) begin
        if (rst_n && out_ch.valid && out_ch.ready) got <= got + 1;
    end

    // Offer one item: idle first at random, then hold valid until the block takes it.
    task automatic push_item(input t_mode m, input logic [BYTE_W-1:0] b,
                             input logic [RIDX_W-1:0] ri);
        while (!calm && $urandom_range(99) < 28) begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.mode       <= m;
        in_ch.rx_byte    <= b;
        in_ch.read_index <= ri;
        @(posedge clk);
        while (in_ch.ready !== 1'b1) @(posedge clk);
        sent++;
    endtask

    task automatic send_tick();
        push_item(MODE_TICK, BYTE_W'($urandom), RIDX_W'($urandom));
    endtask

    // Read only entries already written; the buffer is undefined elsewhere.
    task automatic send_read();
        if (filled > 0)
            push_item(MODE_READ, BYTE_W'($urandom), RIDX_W'($urandom_range(filled - 1)));
    endtask

    // Send a received byte, now and then with a tick or a buffer read slipped in ahead.
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        if ($urandom_range(99) < 4) send_tick();
        if ($urandom_range(99) < 4) send_read();
        push_item(MODE_BYTE, b, RIDX_W'($urandom));
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i]);
    endtask

    // Advance the idle timer past its limit so a partial message is dropped.
    task automatic expire_idle();
        repeat (cur_timeout + 1) send_tick();
    endtask

    function automatic logic [BYTE_W-1:0] text_byte();
        logic [BYTE_W-1:0] v;
        v = BYTE_W'($urandom);
        if (v == CH_CR) v = CH_LF;
        return v;
    endfunction

    // First text byte: anything but a prompt or CR, so the line stays a line.
    function automatic logic [BYTE_W-1:0] line_head();
        logic [BYTE_W-1:0] v;
        v = text_byte();
        if (v == CH_PROMPT) v = "A";
        return v;
    endfunction

    function automatic logic [BYTE_W-1:0] hdr_char();
        string pool;
        pool = "CMGRS:, 09";
        return pool[$urandom_range(pool.len() - 1)];
    endfunction

    // Write the idle timeout only once every result is in and the block has settled.
    task automatic set_timeout(input int v);
        in_ch.valid <= 1'b0;
        while (got != sent) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_wdata <= CFG_W'(v);
        cfg_we    <= 1'b1;
        @(posedge clk);
        cfg_we    <= 1'b0;
        cur_timeout = v;
    endtask

    // One random response: mostly well-formed lines and frames with random content,
    // the rest prompts, broken headers, junk, timeouts and loose noise.
    task automatic random_response();
        int    pick;
        int    n;
        int    k;
        int    variant;
        string digits;
        pick = $urandom_range(99);
        if (pick < 30) begin
            // Line, sometimes closed by CR CR and followed by a second line.
            send_byte(CH_CR);
            send_byte(CH_LF);
            n = $urandom_range(12);
            for (k = 0; k < n; k++) send_byte(k == 0 ? line_head() : text_byte());
            if ($urandom_range(2) == 0) begin
                send_byte(CH_CR);
                send_byte(CH_CR);
                send_byte(CH_LF);
                n = $urandom_range(1, 8);
                for (k = 0; k < n; k++) send_byte(k == 0 ? line_head() : text_byte());
            end
            send_byte(CH_CR);
            send_byte(CH_LF);
        end else if (pick < 55) begin
            // Length header then exactly that many raw bytes.
            n = $urandom_range(1, 24);
            send_byte(CH_PLUS);
            for (k = $urandom_range(6); k > 0; k--) send_byte(hdr_char());
            send_byte(CH_COMMA);
            digits = ($urandom_range(3) == 0) ? $sformatf("%03d", n) : $sformatf("%0d", n);
            send_text(digits);
            send_byte(CH_CR);
            send_byte(CH_LF);
            for (k = 0; k < n; k++) send_byte(BYTE_W'($urandom));
        end else if (pick < 62) begin
            send_byte(CH_CR);
            send_byte(CH_LF);
            send_byte(CH_PROMPT);
        end else if (pick < 75) begin
            // Broken or odd headers; a huge length only where the timer can clear it.
            variant = $urandom_range(5);
            if (variant == 5 && cur_timeout > 50) variant = 2;
            send_byte(CH_PLUS);
            case (variant)
                0: send_text("AT");          // no comma at all
                1: send_text(",1x");         // non-digit in the length
                2: send_text(",0");          // zero length
                3: send_text(",5");          // LF below, with no CR before it
                4: begin                     // zero byte cuts the digits short
                    send_text(",2");
                    send_byte('0);
                    send_text("7");
                end
                default: send_text(",999999");  // saturates the length
            endcase
            if (variant != 3) send_byte(CH_CR);
            send_byte(CH_LF);
            if (variant == 4) begin
                send_byte(BYTE_W'($urandom));
                send_byte(BYTE_W'($urandom));
            end else if (variant == 5) begin
                repeat (3) send_byte(BYTE_W'($urandom));
                expire_idle();
            end
        end else if (pick < 85) begin
            // Junk after the head CR, or after the text CR.
            send_byte(CH_CR);
            if ($urandom_range(1)) begin
                send_byte("Q");
            end else begin
                send_byte(CH_LF);
                send_byte("A");
                send_byte(CH_CR);
                send_byte("B");
            end
        end else if (pick < 92) begin
            // Partial message left to time out.
            send_byte(CH_CR);
            send_byte(CH_LF);
            send_byte("A");
            send_byte("B");
            if (cur_timeout <= 50) expire_idle();
        end else begin
            n = $urandom_range(1, 4);
            for (k = 0; k < n; k++) begin
                case ($urandom_range(2))
                    0: send_byte(BYTE_W'($urandom));
                    1: send_tick();
                    default: send_read();
                endcase
            end
        end
    endtask

    initial begin : stimulus
        int timeouts [6];
        int phase_end;
        timeouts = '{5000, 65535, 1, 3, 2, 17};
        sent        = 0;
        calm        = 1'b0;
        cur_timeout = TIMEOUT_RESET;
        rst_n            <= 1'b0;
        cfg_we           <= 1'b0;
        cfg_wdata        <= '0;
        wrap_up          <= 1'b0;
        in_ch.valid      <= 1'b0;
        in_ch.mode       <= MODE_BYTE;
        in_ch.rx_byte    <= '0;
        in_ch.read_index <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int p = 0; p < 6; p++) begin
            if (p > 0) set_timeout(timeouts[p]);
            // Drop all idling for one whole phase.
            calm = (p == 3);
            if (p == 0) begin
                // Prompt.
                push_item(MODE_BYTE, CH_CR, '0);
                push_item(MODE_BYTE, CH_LF, '1);
                push_item(MODE_BYTE, CH_PROMPT, '0);
                // Two lines, the first closed by CR CR, the second holding 0xFF.
                push_item(MODE_BYTE, CH_CR, '0);
                push_item(MODE_BYTE, CH_LF, '0);
                push_item(MODE_BYTE, "O", '0);
                push_item(MODE_BYTE, "K", '0);
                push_item(MODE_BYTE, CH_CR, '0);
                push_item(MODE_BYTE, CH_CR, '0);
                push_item(MODE_BYTE, CH_LF, '0);
                push_item(MODE_BYTE, '1, '0);
                push_item(MODE_BYTE, CH_CR, '0);
                push_item(MODE_BYTE, CH_LF, '0);
                // Frame of two raw bytes at both byte extremes.
                push_item(MODE_BYTE, CH_PLUS, '0);
                push_item(MODE_BYTE, CH_COMMA, '0);
                push_item(MODE_BYTE, "2", '0);
                push_item(MODE_BYTE, CH_CR, '0);
                push_item(MODE_BYTE, CH_LF, '0);
                push_item(MODE_BYTE, '0, '0);
                push_item(MODE_BYTE, '1, '0);
                // Stray byte while idle arms the timer; a tick with nothing to drop.
                push_item(MODE_BYTE, '1, '0);
                push_item(MODE_TICK, '1, '1);
                push_item(MODE_READ, '1, '0);
                send_read();
            end
            if (p == 1) begin
                // Overrun: one line longer than the buffer wraps the write position
                // and leaves every entry written, so reads may reach any index later.
                send_byte(CH_CR);
                send_byte(CH_LF);
                send_byte(line_head());
                repeat (OVERRUN_BYTES - 1) send_byte(text_byte());
                send_byte(CH_CR);
                send_byte(CH_LF);
            end
            phase_end = sent + PHASE_ITEMS;
            while (sent < phase_end) random_response();
        end

        in_ch.valid <= 1'b0;
        while (got != sent) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        wrap_up <= 1'b1;
        repeat (2) @(posedge clk);
        if (mismatches == 0) begin
            $display("at_response_line_framer_tb: clean");
        end else begin
            $display("at_response_line_framer_tb: errors");
        end
        $finish;
    end

endmodule

// ===== at_response_line_framer.f =====
src/arlf_pkg.sv
src/arlf_ifs.sv
src/at_response_line_framer.sv
tb/sv/arlf_result_check.sv
tb/sv/at_response_line_framer_tb.sv
